// ===== rtl/mandelbrot_escape_time_pixel_core_defines.svh =====
// assertion macros for the mandelbrot escape-time pixel core
// no dependencies
`ifndef MANDELBROT_ESCAPE_TIME_PIXEL_CORE_DEFINES_SVH
`define MANDELBROT_ESCAPE_TIME_PIXEL_CORE_DEFINES_SVH
// implication checked on every edge outside reset
`define MEP_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
// next-cycle implication
`define MEP_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

// ===== rtl/mep_pkg.sv =====
// package for the mandelbrot escape-time pixel core: payload types, palette
// no dependencies
package mep_pkg;
  localparam int FracBitsDef = 27;
  localparam int PaletteEntries = 16;
  localparam int NumCells = 2;
  localparam logic [11:0] MaxIterReset = 12'd50;

  typedef struct packed {
    logic signed [31:0] z_real;
    logic signed [31:0] z_imag;
    logic signed [31:0] c_real;
    logic signed [31:0] c_imag;
  } in_req_t;

  typedef struct packed {
    logic [11:0] iteration_count;
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
  } out_req_t;

  // token passed from cell to cell
  typedef struct packed {
    logic               vld;
    logic               done;
    logic               fresh;
    logic [11:0]        count;
    logic signed [31:0] zr;
    logic signed [31:0] zi;
    logic signed [31:0] cr;
    logic signed [31:0] ci;
  } tok_t;

  function automatic logic [23:0] palette(input logic [3:0] idx);
    logic [23:0] rgb;
    unique case (idx)
      4'd0:  rgb = {8'd66, 8'd30, 8'd15};
      4'd1:  rgb = {8'd25, 8'd7, 8'd26};
      4'd2:  rgb = {8'd9, 8'd1, 8'd47};
      4'd3:  rgb = {8'd4, 8'd4, 8'd73};
      4'd4:  rgb = {8'd0, 8'd7, 8'd100};
      4'd5:  rgb = {8'd12, 8'd44, 8'd138};
      4'd6:  rgb = {8'd24, 8'd82, 8'd177};
      4'd7:  rgb = {8'd57, 8'd125, 8'd209};
      4'd8:  rgb = {8'd134, 8'd181, 8'd229};
      4'd9:  rgb = {8'd211, 8'd236, 8'd248};
      4'd10: rgb = {8'd241, 8'd233, 8'd191};
      4'd11: rgb = {8'd248, 8'd201, 8'd95};
      4'd12: rgb = {8'd255, 8'd170, 8'd0};
      4'd13: rgb = {8'd204, 8'd128, 8'd0};
      4'd14: rgb = {8'd153, 8'd87, 8'd0};
      default: rgb = {8'd106, 8'd52, 8'd3};
    endcase
    return rgb;
  endfunction
endpackage

// ===== rtl/mep_cell.sv =====
// one map cell: two-stage z*z+c evaluation, escape test and count update
// depends on mep_pkg
module mep_cell #(
  parameter int FRAC_BITS = mep_pkg::FracBitsDef
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic [11:0]   max_iter,
  input  mep_pkg::tok_t tok_i,
  output mep_pkg::tok_t tok_o
);
  localparam logic signed [65:0] Two = 66'sd2 <<< FRAC_BITS;

  mep_pkg::tok_t      s1_r;
  logic signed [63:0] rr_r, ii_r, ri_r;
  mep_pkg::tok_t      tok_r;

  // stage 1: products
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_r.vld <= 1'b0;
    end else begin
      s1_r.vld <= tok_i.vld;
    end
    s1_r.done  <= tok_i.done;
    s1_r.fresh <= tok_i.fresh;
    s1_r.count <= tok_i.count;
    s1_r.zr    <= tok_i.zr;
    s1_r.zi    <= tok_i.zi;
    s1_r.cr    <= tok_i.cr;
    s1_r.ci    <= tok_i.ci;
    rr_r <= tok_i.zr * tok_i.zr;
    ii_r <= tok_i.zi * tok_i.zi;
    ri_r <= tok_i.zr * tok_i.zi;
  end

  function automatic logic signed [31:0] sat(input logic signed [65:0] v);
    if (v > 66'sd2147483647) return 32'sh7fffffff;
    if (v < -66'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction

  function automatic logic ins(input logic signed [31:0] v);
    logic signed [65:0] w;
    w = 66'(v);
    return (w <= Two) && (w >= -Two);
  endfunction

  logic signed [65:0] nr_w, ni_w;
  logic signed [31:0] nr, ni;
  logic               first, go;
  mep_pkg::tok_t      nxt;

  always_comb begin
    nr_w = (66'(rr_r) >>> FRAC_BITS) - (66'(ii_r) >>> FRAC_BITS) + 66'(s1_r.cr);
    ni_w = (66'(ri_r) >>> (FRAC_BITS - 1)) + 66'(s1_r.ci);
    nr = sat(nr_w);
    ni = sat(ni_w);
    // the first step of a new point is taken without counting it
    first = s1_r.fresh && !s1_r.done;
    go = !s1_r.done && (first ||
         (ins(s1_r.zr) && ins(s1_r.zi) && s1_r.count < max_iter));
    nxt = s1_r;
    if (go) begin
      nxt.zr = nr;
      nxt.zi = ni;
      nxt.fresh = 1'b0;
      nxt.count = first ? s1_r.count : s1_r.count + 12'd1;
    end else begin
      nxt.done = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tok_r.vld <= 1'b0;
    end else begin
      tok_r.vld <= s1_r.vld;
    end
    tok_r.done  <= nxt.done;
    tok_r.fresh <= nxt.fresh;
    tok_r.count <= nxt.count;
    tok_r.zr    <= nxt.zr;
    tok_r.zi    <= nxt.zi;
    tok_r.cr    <= nxt.cr;
    tok_r.ci    <= nxt.ci;
  end

  assign tok_o = tok_r;
endmodule

// ===== rtl/mandelbrot_escape_time_pixel_core.sv =====
// Mandelbrot escape-time pixel core. One point is in flight at a time. It
// circulates round a ring of two map cells, each a two-stage multiply/add
// pipeline. A point with n counted iterations needs n+2 passes (the
// uncounted first step, n counted steps and the pass that finds it done),
// rounded up to an even number so that it leaves at the end of a lap. When
// it retires at the ring head its result is registered into the output
// register, and the next request can be taken in the cycle in which that
// result appears on out. The result waits in the output register; if that
// register is still stalled when a point is done, the point goes round the
// ring again, lap by lap, until the register is free and it retires.
// depends on mep_pkg, mep_cell and the defines header
`include "mandelbrot_escape_time_pixel_core_defines.svh"
module mandelbrot_escape_time_pixel_core #(
  parameter int FRAC_BITS = mep_pkg::FracBitsDef
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  mep_pkg::in_req_t in_data,
  output logic             out_valid,
  input  logic             out_stall,
  output mep_pkg::out_req_t out_data,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [11:0]      cfg_data
);
  logic [11:0]       max_iter_r;
  logic              busy_r;
  logic              out_valid_r;
  mep_pkg::out_req_t out_r;
  mep_pkg::tok_t     ring [mep_pkg::NumCells+1];
  mep_pkg::tok_t     inj;
  logic              accept, finish;
  logic [23:0]       rgb;

  assign cfg_ready = 1'b1;
  assign in_stall  = busy_r;
  assign accept    = in_valid && !busy_r;
  // the token returns to the ring head; retire once done and output free
  assign finish    = ring[mep_pkg::NumCells].vld && ring[mep_pkg::NumCells].done &&
                     (!out_valid_r || !out_stall);

  always_comb begin
    inj = ring[mep_pkg::NumCells];
    if (finish) inj.vld = 1'b0;
    if (accept) begin
      inj.vld   = 1'b1;
      inj.done  = 1'b0;
      inj.fresh = 1'b1;
      inj.count = 12'd0;
      inj.zr    = in_data.z_real;
      inj.zi    = in_data.z_imag;
      inj.cr    = in_data.c_real;
      inj.ci    = in_data.c_imag;
    end
  end

  assign ring[0] = inj;

  for (genvar g = 0; g < mep_pkg::NumCells; g++) begin : g_cell
    mep_cell #(.FRAC_BITS(FRAC_BITS)) u_cell (
      .clk(clk), .rst_n(rst_n), .max_iter(max_iter_r),
      .tok_i(ring[g]), .tok_o(ring[g+1])
    );
  end

  assign rgb = mep_pkg::palette(ring[mep_pkg::NumCells].count[3:0]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_iter_r  <= mep_pkg::MaxIterReset;
      busy_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_valid) max_iter_r <= cfg_data;
      if (accept) busy_r <= 1'b1;
      else if (finish) busy_r <= 1'b0;
      if (finish) out_valid_r <= 1'b1;
      else if (!out_stall) out_valid_r <= 1'b0;
    end
    if (finish) begin
      out_r.iteration_count <= ring[mep_pkg::NumCells].count;
      out_r.red   <= rgb[23:16];
      out_r.green <= rgb[15:8];
      out_r.blue  <= rgb[7:0];
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  `MEP_ASSERT_IMP(a_no_accept_busy, busy_r, !accept)
  `MEP_ASSERT_NXT(a_finish_out, finish, out_valid && !busy_r)
  `MEP_ASSERT_IMP(a_count_bound, finish, ring[mep_pkg::NumCells].count <= max_iter_r)
endmodule

// ===== tb/mandelbrot_escape_time_pixel_core_tb.sv =====
// testbench for the mandelbrot escape-time pixel core: predicts count and colour
// for each request and checks results in order; depends on mep_pkg and the core
`timescale 1ns / 100ps
module mandelbrot_escape_time_pixel_core_tb;
  localparam int FracBits = 27;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  mep_pkg::in_req_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  mep_pkg::out_req_t out_data;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [11:0] cfg_data = '0;

  mandelbrot_escape_time_pixel_core dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  mep_pkg::in_req_t pending_points[$];
  mep_pkg::out_req_t expected_pixels[$];
  logic [11:0] iter_limit = mep_pkg::MaxIterReset;
  int idle_pct = 0;
  int stall_pct = 0;
  int errors = 0;

  // tb's own palette, independent of the package function
  logic [23:0] colour_lut [16] = '{
    {8'd66, 8'd30, 8'd15}, {8'd25, 8'd7, 8'd26}, {8'd9, 8'd1, 8'd47},
    {8'd4, 8'd4, 8'd73}, {8'd0, 8'd7, 8'd100}, {8'd12, 8'd44, 8'd138},
    {8'd24, 8'd82, 8'd177}, {8'd57, 8'd125, 8'd209}, {8'd134, 8'd181, 8'd229},
    {8'd211, 8'd236, 8'd248}, {8'd241, 8'd233, 8'd191}, {8'd248, 8'd201, 8'd95},
    {8'd255, 8'd170, 8'd0}, {8'd204, 8'd128, 8'd0}, {8'd153, 8'd87, 8'd0},
    {8'd106, 8'd52, 8'd3}
  };

  function automatic longint clamp32(input longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic bit in_range(input longint v);
    longint two;
    two = longint'(2) <<< FracBits;
    return (v <= two) && (v >= -two);
  endfunction

  function automatic mep_pkg::out_req_t escape_pixel(input mep_pkg::in_req_t p,
                                                     input logic [11:0] lim);
    longint zr, zi, cr, ci, rr, ii, ri;
    int unsigned cnt;
    mep_pkg::out_req_t r;
    zr = p.z_real; zi = p.z_imag; cr = p.c_real; ci = p.c_imag;
    cnt = 0;
    for (int s = 0; s < 4097; s++) begin
      // arithmetic shift on signed longint rounds toward minus infinity
      rr = (zr * zr) >>> FracBits;
      ii = (zi * zi) >>> FracBits;
      ri = (zr * zi) >>> (FracBits - 1);
      zr = clamp32(rr - ii + cr);
      zi = clamp32(ri + ci);
      if (!(in_range(zr) && in_range(zi) && cnt < lim)) break;
      if (s > 0) cnt++;
      else if (cnt < lim) cnt++;
    end
    r.iteration_count = cnt[11:0];
    {r.red, r.green, r.blue} = colour_lut[cnt[3:0]];
    return r;
  endfunction

  // driver: one nonblocking write per signal per edge
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall) begin
        expected_pixels.push_back(escape_pixel(in_data, iter_limit));
        void'(pending_points.pop_front());
      end
      if (!(in_valid && in_stall)) begin
        if (pending_points.size() > (in_valid && !in_stall ? 0 : 0) &&
            pending_points.size() > 0 && $urandom_range(99) >= idle_pct) begin
          in_valid <= 1'b1;
          in_data <= pending_points[0];
        end else begin
          in_valid <= 1'b0;
          in_data <= mep_pkg::in_req_t'({$urandom, $urandom, $urandom, $urandom});
        end
      end
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  // monitor
  always @(posedge clk) begin
    mep_pkg::out_req_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_pixels.size() == 0) begin
        $error("unexpected result count=%0d", out_data.iteration_count);
        errors++;
      end else begin
        want = expected_pixels.pop_front();
        if (want.iteration_count !== out_data.iteration_count) begin
          $error("iteration_count exp %0d got %0d", want.iteration_count,
                 out_data.iteration_count);
          errors++;
        end
        if (want.red !== out_data.red) begin
          $error("red exp %0d got %0d", want.red, out_data.red); errors++;
        end
        if (want.green !== out_data.green) begin
          $error("green exp %0d got %0d", want.green, out_data.green); errors++;
        end
        if (want.blue !== out_data.blue) begin
          $error("blue exp %0d got %0d", want.blue, out_data.blue); errors++;
        end
      end
    end
  end

  function automatic logic [31:0] near_plane();
    // mostly values in [-2.5, 2.5], sometimes fully random
    if ($urandom_range(9) == 0) return $urandom;
    return 32'($signed($urandom_range(0, 32'd671088640)) - 32'sd335544320);
  endfunction

  task automatic add_point(input logic [31:0] zr, zi, cr, ci);
    mep_pkg::in_req_t p;
    p.z_real = zr; p.z_imag = zi; p.c_real = cr; p.c_imag = ci;
    pending_points.push_back(p);
  endtask

  task automatic drain_all();
    while (pending_points.size() > 0 || in_valid || expected_pixels.size() > 0)
      @(posedge clk);
    repeat (120) @(posedge clk);
  endtask

  task automatic set_limit(input logic [11:0] v);
    drain_all();
    cfg_data <= v;
    cfg_valid <= 1'b1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    iter_limit = v;
  endtask

  task automatic random_points(input int n);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(3) == 0) add_point(32'd0, 32'd0, near_plane(), near_plane());
      else add_point(near_plane(), near_plane(), near_plane(), near_plane());
    end
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    // directed: extremes, origin, escape, saturation, boundary 2.0
    add_point(32'd0, 32'd0, 32'd0, 32'd0);
    add_point(32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff);
    add_point(32'h80000000, 32'h80000000, 32'h80000000, 32'h80000000);
    add_point(32'h80000000, 32'h7fffffff, 32'h00000000, 32'hffffffff);
    add_point(32'd0, 32'd0, 32'h10000000, 32'd0);
    add_point(32'd0, 32'd0, 32'hf0000000, 32'd0);
    add_point(32'd0, 32'd0, 32'h10000001, 32'd0);
    add_point(32'd0, 32'd0, 32'd0, 32'h10000000);
    add_point(32'd0, 32'd0, 32'hfa000000, 32'h01000000);
    add_point(32'd0, 32'd0, 32'h02000000, 32'h08000000);
    add_point(32'hffffffff, 32'hffffffff, 32'hffffffff, 32'hffffffff);
    add_point(32'h55555555, 32'haaaaaaaa, 32'h33333333, 32'hcccccccc);
    drain_all();
    set_limit(12'd0);
    add_point(32'd0, 32'd0, 32'd0, 32'd0);
    add_point(32'd0, 32'd0, 32'h7fffffff, 32'd0);
    random_points(40);
    set_limit(12'd4095);
    add_point(32'd0, 32'd0, 32'd0, 32'd0);
    add_point(32'd0, 32'd0, 32'hfc000000, 32'd0);
    set_limit(12'd1);
    random_points(60);
    set_limit(12'd17);
    random_points(200);
    set_limit(mep_pkg::MaxIterReset);
    for (int ph = 0; ph < 4; ph++) begin
      idle_pct = (ph == 1 || ph == 3) ? (ph == 1 ? 46 : 37) : 0;
      stall_pct = (ph == 2 || ph == 3) ? (ph == 2 ? 46 : 37) : 0;
      random_points(160);
      drain_all();
    end
    idle_pct = 20; stall_pct = 20;
    set_limit(12'($urandom_range(2, 120)));
    random_points(100);
    drain_all();
    if (errors == 0) $display("PASS mandelbrot_escape_time_pixel_core");
    else $display("FAIL mandelbrot_escape_time_pixel_core");
    $finish;
  end

  initial begin
    #40000000;
    $display("FAIL mandelbrot_escape_time_pixel_core");
    $finish;
  end
endmodule
